// ===== rtl/assert_macros.svh =====
// Assertion macros used by the matrix3x3_inverse_core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define M3I_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("m3i assertion failed");
`define M3I_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("m3i sequence assertion failed");
`else
`define M3I_ASSERT(lbl, prop)
`define M3I_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

// ===== rtl/m3i_pkg.sv =====
package m3i_pkg;

    localparam int LANES      = 9;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 32;
    localparam int PROD_W     = 2 * IN_W;
    localparam int ADJ_W      = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int DP_W       = IN_W + ADJ_W;
    localparam int DET_W      = DP_W + 2;
    localparam int DEN_W      = 48;
    localparam int FRAC_SHIFT = 28;
    localparam int QBITS      = 34;
    localparam int NB_W       = QBITS - FRAC_SHIFT - 1;
    localparam int FRONT_LAT  = 4;
    localparam int LANE_LAT   = QBITS + 1;
    localparam int PIPE_LAT   = FRONT_LAT + LANE_LAT + 1;

    localparam logic [3:0] IDX_A [LANES] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
    localparam logic [3:0] IDX_B [LANES] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
    localparam logic [3:0] IDX_C [LANES] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};
    localparam logic [3:0] IDX_D [LANES] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
    localparam logic [LANES-1:0] NEG_MASK = 9'b010101010;

    localparam logic [QBITS-1:0] POS_LIMIT = QBITS'(34'h07FFFFFFF);
    localparam logic [QBITS-1:0] NEG_LIMIT = QBITS'(34'h080000000);

    typedef struct packed {
        logic [LANES-1:0][MAG_W-1:0] adj_mag;
        logic [LANES-1:0]            neg;
        logic [DEN_W-1:0]            den;
        logic                        singular;
    } m3i_front_t;

    typedef struct packed {
        logic [QBITS-1:0] q2;
        logic             big;
        logic             neg;
    } m3i_lane_t;

endpackage

// ===== rtl/matrix3x3_inverse_core.sv =====
// Throughput: one matrix per cycle while the output is not stalled, set by a fully pipelined
// datapath that has nine divider lanes of one quotient bit per stage.
// Stalls at the output freeze the whole pipeline together.
// Reset (rst_n, asynchronous, active low) clears the valid bits only.
`include "assert_macros.svh"

module matrix3x3_inverse_core
    import m3i_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // a00, a01, a02, a10, a11, a12, a20, a21, a22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic [1:0]   m_tuser    // singular, overflow
);

    logic                         adv;
    logic [PIPE_LAT-1:0]          vld_reg;
    logic [LANE_LAT-1:0]          sing_reg;
    logic [LANES-1:0][IN_W-1:0]   a;
    m3i_front_t                   front;
    m3i_lane_t [LANES-1:0]        lanes;
    logic [LANES-1:0][OUT_W-1:0]  r;
    logic                         singular;
    logic                         overflow;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign a        = s_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sing_reg <= {sing_reg[LANE_LAT-2:0], front.singular};
        end
    end

    m3i_front u_front (
        .clk (clk),
        .en  (adv),
        .a   (a),
        .res (front)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        m3i_div_lane u_lane (
            .clk     (clk),
            .en      (adv),
            .adj_mag (front.adj_mag[k]),
            .den     (front.den),
            .neg     (front.neg[k]),
            .res     (lanes[k])
        );
    end

    m3i_merge u_merge (
        .clk         (clk),
        .en          (adv),
        .lanes       (lanes),
        .singular_in (sing_reg[LANE_LAT-1]),
        .r           (r),
        .singular    (singular),
        .overflow    (overflow)
    );

    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign m_tdata  = r;
    assign m_tuser  = {overflow, singular};

    `M3I_ASSERT(a_singular_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
    `M3I_ASSERT(a_ready_follows_output, s_tready == (!m_tvalid || m_tready))
    `M3I_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0])

endmodule

// ===== rtl/m3i_front.sv =====
module m3i_front
    import m3i_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [LANES-1:0][IN_W-1:0]  a,
    output m3i_front_t                  res
);

    logic signed [PROD_W-1:0] pa_reg [LANES];
    logic signed [PROD_W-1:0] pb_reg [LANES];
    logic signed [ADJ_W-1:0]  adj_reg [LANES];
    logic signed [ADJ_W-1:0]  adj3_reg [LANES];
    logic signed [IN_W-1:0]   r1_reg [3];
    logic signed [IN_W-1:0]   r2_reg [3];
    logic signed [DP_W-1:0]   dp_reg [3];
    m3i_front_t               res_reg;
    m3i_front_t               res_next;
    logic signed [DET_W-1:0]  det;
    logic [DET_W-1:0]         det_mag;

    for (genvar k = 0; k < LANES; k++) begin : g_cof
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[k]   <= $signed(a[IDX_A[k]]) * $signed(a[IDX_B[k]]);
                pb_reg[k]   <= $signed(a[IDX_C[k]]) * $signed(a[IDX_D[k]]);
                adj_reg[k]  <= NEG_MASK[k] ? (ADJ_W'(pb_reg[k]) - ADJ_W'(pa_reg[k]))
                                           : (ADJ_W'(pa_reg[k]) - ADJ_W'(pb_reg[k]));
                adj3_reg[k] <= adj_reg[k];
            end
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r1_reg[j] <= $signed(a[j]);
                r2_reg[j] <= r1_reg[j];
                dp_reg[j] <= DP_W'(r2_reg[j]) * DP_W'(adj_reg[3 * j]);
            end
        end
    end

    always_comb
    begin
        det = DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
        det_mag = det[DET_W-1] ? -det : det;
        res_next.den = det_mag[DEN_W-1:0];
        res_next.singular = (det == '0);
        for (int k = 0; k < LANES; k++)
        begin
            res_next.adj_mag[k] = adj3_reg[k][ADJ_W-1] ? MAG_W'(-adj3_reg[k])
                                                       : MAG_W'(adj3_reg[k]);
            res_next.neg[k] = adj3_reg[k][ADJ_W-1] ^ det[DET_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/m3i_div_lane.sv =====
module m3i_div_lane
    import m3i_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] adj_mag,
    input  logic [DEN_W-1:0] den,
    input  logic             neg,
    output m3i_lane_t        res
);

    localparam int HI_W = MAG_W - NB_W;

    logic [DEN_W-1:0] rem_reg [QBITS+1];
    logic [DEN_W-1:0] den_reg [QBITS+1];
    logic [NB_W-1:0]  nb_reg  [QBITS+1];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic             big_reg [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic [HI_W-1:0]  hi;
    logic             big_init;

    assign hi = adj_mag[MAG_W-1:NB_W];
    assign big_init = (DEN_W'(hi) >= den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= big_init ? '0 : DEN_W'(hi);
            den_reg[0] <= den;
            nb_reg[0]  <= adj_mag[NB_W-1:0];
            q_reg[0]   <= '0;
            big_reg[0] <= big_init;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_step
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb
        begin
            t    = {rem_reg[k-1], nb_reg[k-1][NB_W-1]};
            diff = t - {1'b0, den_reg[k-1]};
            ge   = (t >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                den_reg[k] <= den_reg[k-1];
                nb_reg[k]  <= {nb_reg[k-1][NB_W-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QBITS-2:0], ge};
                big_reg[k] <= big_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign res.q2  = q_reg[QBITS];
    assign res.big = big_reg[QBITS];
    assign res.neg = neg_reg[QBITS];

endmodule

// ===== rtl/m3i_merge.sv =====
module m3i_merge
    import m3i_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  m3i_lane_t [LANES-1:0]       lanes,
    input  logic                        singular_in,
    output logic [LANES-1:0][OUT_W-1:0] r,
    output logic                        singular,
    output logic                        overflow
);

    logic [LANES-1:0][OUT_W-1:0] r_reg;
    logic [LANES-1:0][OUT_W-1:0] r_next;
    logic                        singular_reg;
    logic                        overflow_reg;
    logic                        overflow_next;
    logic [LANES-1:0]            sat;

    always_comb
    begin
        logic [QBITS:0]   qr;
        logic [QBITS-1:0] q;
        overflow_next = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            qr = {1'b0, lanes[k].q2} + (QBITS+1)'(1);
            q  = qr[QBITS:1];
            if (lanes[k].neg)
            begin
                sat[k] = lanes[k].big || (q > NEG_LIMIT);
                r_next[k] = sat[k] ? NEG_LIMIT[OUT_W-1:0] : -q[OUT_W-1:0];
            end
            else
            begin
                sat[k] = lanes[k].big || (q > POS_LIMIT);
                r_next[k] = sat[k] ? POS_LIMIT[OUT_W-1:0] : q[OUT_W-1:0];
            end
            if (singular_in)
            begin
                r_next[k] = '0;
            end
            overflow_next = overflow_next | sat[k];
        end
        if (singular_in)
        begin
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg        <= r_next;
            singular_reg <= singular_in;
            overflow_reg <= overflow_next;
        end
    end

    assign r        = r_reg;
    assign singular = singular_reg;
    assign overflow = overflow_reg;

endmodule
